/* rtl/red_pkg.sv */
`default_nettype none

package red_pkg;

	// Field widths of the item, result and configuration channels
	localparam int ENC_W   = 6;
	localparam int PINS_W  = 2;
	localparam int COUNT_W = 8;
	localparam int CFGA_W  = 2;
	localparam int CFGD_W  = 8;

	// Queue between front and back
	localparam int QDEPTH = 2;
	localparam int QAW    = 1;
	localparam int QCW    = 2;

	// Register indexes on the configuration channel
	localparam logic [CFGA_W-1:0] REG_EDGE_MASK  = 2'd0;
	localparam logic [CFGA_W-1:0] REG_SPEED_MODE = 2'd1;
	localparam logic [CFGA_W-1:0] REG_SPEED_PAR  = 2'd2;

	// Speed mode codes; the unused code behaves as normal
	localparam logic [1:0] MODE_NORMAL = 2'd0;
	localparam logic [1:0] MODE_FAST   = 2'd1;
	localparam logic [1:0] MODE_SLOW   = 2'd2;

	typedef enum logic {
		CMD_SCAN    = 1'b0,
		CMD_COLLECT = 1'b1
	} cmd_t;

	// Shared configuration
	typedef struct packed {
		logic [7:0] edge_mask;
		logic [1:0] speed_mode;
		logic [2:0] step_sel;
	} cfg_t;

	// Classified item as it waits in the queue
	typedef struct packed {
		cmd_t              cmd;
		logic [ENC_W-1:0]  encoder;
		logic              in_range;
		logic [PINS_W-1:0] pins;
		logic              changed;
	} qent_t;

	// Per-encoder state word
	typedef struct packed {
		logic [3:0]         pin_history;
		logic               last_was_down;
		logic [COUNT_W-1:0] count;
		logic [7:0]         speed_timer;
		logic [3:0]         last_down_state;
		logic [3:0]         last_up_state;
		logic [7:0]         previous_speed;
		logic [3:0]         slow_divider;
	} enc_word_t;

	localparam enc_word_t STATE_RESET = '{
		pin_history:     4'hF,
		last_was_down:   1'b0,
		count:           8'h00,
		speed_timer:     8'h00,
		last_down_state: 4'h0,
		last_up_state:   4'h0,
		previous_speed:  8'h00,
		slow_divider:    4'h0
	};

endpackage

`default_nettype wire

/* rtl/red_if.sv */
`default_nettype none

interface red_item_if import red_pkg::*; ();
	logic              valid;
	logic              ready;
	cmd_t              cmd;
	logic [ENC_W-1:0]  encoder;
	logic [PINS_W-1:0] pins;
	logic              changed;

	modport source (output valid, cmd, encoder, pins, changed, input ready);
	modport sink   (input valid, cmd, encoder, pins, changed, output ready);
endinterface

interface red_result_if import red_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [ENC_W-1:0]          encoder_out;
	logic signed [COUNT_W-1:0] delta;
	logic                      moved;

	modport source (output valid, encoder_out, delta, moved, input ready);
	modport sink   (input valid, encoder_out, delta, moved, output ready);
endinterface

interface red_cfg_if import red_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CFGA_W-1:0] index;
	logic [CFGD_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/red_ram.sv */
`default_nettype none

module red_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                                           clk,
	input  wire logic                                           we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                               wdata,
	input  wire logic                                           re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output      logic [WIDTH-1:0]                               rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* rtl/red_front.sv */
`default_nettype none

module red_front import red_pkg::*; #(
	parameter int ENCODERS = 64
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	red_item_if.sink   item,
	red_cfg_if.sink    cfg,
	input  wire logic  full,
	output      logic  push,
	output      qent_t push_ent,
	output      cfg_t  cfg_out
);

	localparam logic [8:0] ENC_LIM = 9'(ENCODERS);

	cfg_t cfg_q;

	// Configuration registers; writes beyond the list are dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_EDGE_MASK:  cfg_q.edge_mask  <= cfg.data;
				REG_SPEED_MODE: cfg_q.speed_mode <= cfg.data[1:0];
				REG_SPEED_PAR:  cfg_q.step_sel   <= cfg.data[2:0];
				default: ;
			endcase
		end
	end

	assign cfg_out = cfg_q;

	// Accept an item while the queue has room and tag it with its range check
	assign item.ready = !full;
	assign push       = item.valid && !full;

	always_comb begin
		push_ent.cmd      = item.cmd;
		push_ent.encoder  = item.encoder;
		push_ent.in_range = ({3'b000, item.encoder} < ENC_LIM);
		push_ent.pins     = item.pins;
		push_ent.changed  = item.changed;
	end

endmodule

`default_nettype wire

/* rtl/red_queue.sv */
`default_nettype none

module red_queue import red_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire qent_t push_ent,
	output      logic  full,
	input  wire logic  pop,
	output      qent_t head,
	output      logic  nempty
);

	qent_t           ent_q [QDEPTH];
	logic [QAW-1:0]  wr_ptr_q;
	logic [QAW-1:0]  rd_ptr_q;
	logic [QCW-1:0]  count_q;

	assign full   = (count_q == QCW'(QDEPTH));
	assign nempty = (count_q != '0);
	assign head   = ent_q[rd_ptr_q];

	// Store an entry on push
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_ent;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != QCW'(QDEPTH)))
		else $error("queue written while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("queue read while empty");

endmodule

`default_nettype wire

/* rtl/red_back.sv */
`default_nettype none

module red_back import red_pkg::*; #(
	parameter int ENCODERS = 64
) (
	input  wire logic                                                   clk,
	input  wire logic                                                   arst_n,
	input  wire cfg_t                                                   cfg,
	input  wire qent_t                                                  head,
	input  wire logic                                                   nempty,
	output      logic                                                   pop,
	output      logic                                                   ram_we,
	output      logic [((ENCODERS > 1) ? $clog2(ENCODERS) : 1)-1:0]   ram_waddr,
	output      enc_word_t                                              ram_wdata,
	output      logic                                                   ram_re,
	output      logic [((ENCODERS > 1) ? $clog2(ENCODERS) : 1)-1:0]   ram_raddr,
	input  wire enc_word_t                                              ram_rdata,
	red_result_if.source                                                result
);

	localparam int AW = (ENCODERS > 1) ? $clog2(ENCODERS) : 1;

	localparam logic [3:0] ST_DN0 = 4'h1;
	localparam logic [3:0] ST_DN1 = 4'h7;
	localparam logic [3:0] ST_DN2 = 4'hE;
	localparam logic [3:0] ST_DN3 = 4'h8;
	localparam logic [3:0] ST_UP0 = 4'h2;
	localparam logic [3:0] ST_UP1 = 4'hB;
	localparam logic [3:0] ST_UP2 = 4'hD;
	localparam logic [3:0] ST_UP3 = 4'h4;

	localparam logic [7:0] FAST_LIM   = 8'hE0;
	localparam logic [7:0] JUMP_MAX   = 8'd20;
	localparam logic [7:0] TIMER_LOAD = 8'hFF;

	logic                 adv;
	logic                 valid_s2;
	qent_t                ent_s2;
	logic                 hit_s2;
	logic [AW-1:0]        addr_s2;
	logic [ENCODERS-1:0]  valid_q;
	logic                 byp_vld_q;
	logic [AW-1:0]        byp_addr_q;
	enc_word_t            byp_data_q;
	logic                 out_vld_q;
	logic [ENC_W-1:0]     enc_q;
	logic [COUNT_W-1:0]   delta_q;
	logic                 moved_q;

	enc_word_t            cur;
	enc_word_t            nxt;
	logic [COUNT_W-1:0]   delta_nxt;
	logic                 we_nxt;

	// Back end moves when the output slot is free or being emptied
	assign adv       = !out_vld_q || result.ready;
	assign pop       = adv && nempty;
	assign ram_re    = pop && head.in_range;
	assign ram_raddr = AW'({{AW{1'b0}}, head.encoder});
	assign addr_s2   = AW'({{AW{1'b0}}, ent_s2.encoder});

	// Stage 2 control and payload, captured alongside the memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= nempty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_s2 <= head;
			hit_s2 <= valid_q[ram_raddr];
		end
	end

	// Work out the new state of the addressed encoder
	always_comb begin
		logic [7:0] timer_dec;
		logic [3:0] code;
		logic       dn;
		logic       up;
		logic       move;
		logic       fast;
		logic [8:0] jump;
		logic [7:0] t_cl;
		logic [7:0] step;
		logic [2:0] sh;
		logic [3:0] sstep;
		logic [4:0] ssum;
		logic [4:0] sdiff;

		cur = hit_s2 ? ram_rdata : STATE_RESET;
		if (byp_vld_q && (byp_addr_q == addr_s2)) begin
			cur = byp_data_q;
		end
		nxt = cur;

		timer_dec = (cur.speed_timer != 8'd0) ? cur.speed_timer - 8'd1 : 8'd0;
		code      = {cur.pin_history[1:0], ent_s2.pins};
		dn = ((code == ST_DN0) && cfg.edge_mask[4]) || ((code == ST_DN1) && cfg.edge_mask[5])
			|| ((code == ST_DN2) && cfg.edge_mask[6]) || ((code == ST_DN3) && cfg.edge_mask[7]);
		up = ((code == ST_UP0) && cfg.edge_mask[0]) || ((code == ST_UP1) && cfg.edge_mask[1])
			|| ((code == ST_UP2) && cfg.edge_mask[2]) || ((code == ST_UP3) && cfg.edge_mask[3]);
		fast = (timer_dec > FAST_LIM);
		if (dn) begin
			move = (cur.last_was_down || !fast) && (code != cur.last_down_state);
		end else if (up) begin
			move = (!cur.last_was_down || !fast) && (code != cur.last_up_state);
		end else begin
			move = 1'b0;
		end

		// Limit how fast the speed may rise between moves
		jump = {1'b0, timer_dec} - {1'b0, cur.previous_speed};
		t_cl = (!jump[8] && (jump[7:0] > JUMP_MAX)) ? cur.previous_speed + JUMP_MAX
			: timer_dec;

		sh   = 3'd7 - cfg.step_sel;
		step = t_cl >> sh;
		if (step == 8'd0) begin
			step = 8'd1;
		end
		sstep = {1'b0, cfg.step_sel} + 4'd1;
		ssum  = {1'b0, cur.slow_divider} + {1'b0, sstep};
		sdiff = {1'b0, cur.slow_divider} - {1'b0, sstep};

		we_nxt    = 1'b0;
		delta_nxt = '0;
		if (ent_s2.in_range) begin
			we_nxt = 1'b1;
			if (ent_s2.cmd == CMD_COLLECT) begin
				delta_nxt = cur.count;
				nxt.count = '0;
			end else begin
				if (cfg.edge_mask != 8'd0) begin
					nxt.speed_timer = timer_dec;
					if (ent_s2.changed) begin
						nxt.pin_history = code;
						if (move) begin
							case (cfg.speed_mode)
								MODE_FAST: begin
									nxt.count = dn ? cur.count - step : cur.count + step;
								end
								MODE_SLOW: begin
									if (dn) begin
										nxt.count        = sdiff[4] ? cur.count - 8'd1 : cur.count;
										nxt.slow_divider = sdiff[3:0];
									end else begin
										nxt.count        = ssum[4] ? cur.count + 8'd1 : cur.count;
										nxt.slow_divider = ssum[3:0];
									end
								end
								default: begin
									nxt.count = dn ? cur.count - 8'd1 : cur.count + 8'd1;
								end
							endcase
							nxt.last_was_down  = dn;
							nxt.previous_speed = t_cl;
							nxt.speed_timer    = TIMER_LOAD;
							if (dn) begin
								nxt.last_down_state = code;
							end else begin
								nxt.last_up_state = code;
							end
						end
					end
				end
				delta_nxt = nxt.count;
			end
		end
	end

	assign ram_we    = adv && valid_s2 && we_nxt;
	assign ram_waddr = addr_s2;
	assign ram_wdata = nxt;

	// Written entries become valid; hold the last write for the next read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			byp_vld_q <= 1'b0;
		end else begin
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			if (adv) begin
				byp_vld_q <= ram_we;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			byp_addr_q <= addr_s2;
			byp_data_q <= nxt;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			enc_q   <= ent_s2.encoder;
			delta_q <= delta_nxt;
			moved_q <= (delta_nxt != '0);
		end
	end

	assign result.valid       = out_vld_q;
	assign result.encoder_out = enc_q;
	assign result.delta       = delta_q;
	assign result.moved       = moved_q;

	a_out_of_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && valid_s2 && !ent_s2.in_range) |=> (out_vld_q && (delta_q == '0) && !moved_q))
		else $error("encoder outside the bank gave a nonzero result");

	a_moved_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (moved_q == (delta_q != '0)))
		else $error("moved flag disagrees with delta");

	a_collect_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && (ent_s2.cmd == CMD_COLLECT)) |-> (ram_wdata.count == '0))
		else $error("collect left a nonzero count");

	a_bypass_valid: assert property (@(posedge clk) disable iff (!arst_n)
		byp_vld_q |-> valid_q[byp_addr_q])
		else $error("forwarded entry not marked valid");

endmodule

`default_nettype wire

/* rtl/rotary_encoder_accel_decoder.sv */
// Path: an item passes through the queue, the stage 2 register and the output register.
// Throughput: one item per cycle unless results stall; state memory is read before the
// update; the last write is forwarded, so repeated hits on one encoder run at full rate.
// Reset: configuration clears to zero and all encoders read as released pins, zero count
// and zero timers at once through per-entry valid bits; no clearing pass is needed.
`default_nettype none

module rotary_encoder_accel_decoder import red_pkg::*; #(
	parameter int ENCODERS = 64
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	red_item_if.sink      item,
	red_cfg_if.sink       cfg,
	red_result_if.source  result
);

	localparam int AW = (ENCODERS > 1) ? $clog2(ENCODERS) : 1;

	logic          push;
	qent_t         push_ent;
	logic          full;
	logic          pop;
	qent_t         head;
	logic          nempty;
	cfg_t          cfg_cur;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	enc_word_t     ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	enc_word_t     ram_rdata;

	// Accept and classify items, hold configuration
	red_front #(.ENCODERS(ENCODERS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cfg      (cfg),
		.full     (full),
		.push     (push),
		.push_ent (push_ent),
		.cfg_out  (cfg_cur)
	);

	// Decouple front and back
	red_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_ent (push_ent),
		.full     (full),
		.pop      (pop),
		.head     (head),
		.nempty   (nempty)
	);

	// Per-encoder state memory
	red_ram #(.WIDTH($bits(enc_word_t)), .DEPTH(ENCODERS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Decode, update and deliver
	red_back #(.ENCODERS(ENCODERS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_cur),
		.head      (head),
		.nempty    (nempty),
		.pop       (pop),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.result    (result)
	);

endmodule

`default_nettype wire
